// File: rtl/ffpa_pkg.sv
// Shared constants and types for the first-fit pool allocator.
package ffpa_pkg;
  localparam int POOL_BYTES    = 4096;
  localparam int GRANULE_BYTES = 8;
  localparam int HEADER_BYTES  = 16;
  localparam int NGRAN         = POOL_BYTES / GRANULE_BYTES;
  localparam int GRAN_LG       = $clog2(GRANULE_BYTES);
  localparam int PTR_W         = $clog2(NGRAN);
  localparam int BYTES_W       = 12;
  localparam int OFF_W         = 14;
  localparam int ENT_W         = BYTES_W + 2;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_SPARE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_ZERO     = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_t;

  typedef struct packed {
    logic                 st;
    logic                 fr;
    logic [BYTES_W-1:0]   bytes;
  } ent_t;
endpackage

// File: rtl/ffpa_ram.sv
// Generic simple dual-port RAM with registered read.
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/first_fit_pool_allocator.sv
// First-fit pool allocator: block list walker with split and coalesce.
//
//  channel | ports                         | handshake
//  input   | in_req_type/size/addr         | start, busy
//  result  | out_status .. out_free_count  | out_valid strobe, one cycle
//
// One block-list entry is visited per cycle through the single RAM read port.
// Busy stays high through the request's setup states, then for each block visited by the alloc or
// merge walk and for each block of the statistics walk; out_valid rises in the cycle in which
// busy falls. The list holds at most 170 blocks, so each walk is bounded by that.
// After reset the block clears all NGRAN (512) list RAM entries, busy high.
// The result is shown for one cycle; the receiver cannot stall it.
module first_fit_pool_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [12:0] in_req_size,
  input  logic [12:0] in_req_addr,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [11:0] out_data_addr,
  output logic [12:0] out_total_free,
  output logic [12:0] out_largest_free,
  output logic [9:0]  out_free_count
);
  import ffpa_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_WALK, S_A_W2, S_F_CHK, S_M_INIT, S_M_CUR, S_M_NXT,
    S_M_FLUSH, S_ST_INIT, S_ST_WALK
  } state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W:0]     clr_r, clr_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [OFF_W-1:0]   rsize_r, rsize_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [11:0]        daddr_r, daddr_nxt;
  logic [PTR_W-1:0]   cur_g_r, cur_g_nxt;
  logic               cur_fr_r, cur_fr_nxt;
  logic [BYTES_W-1:0] cur_b_r, cur_b_nxt;
  logic               dirty_r, dirty_nxt;
  logic [12:0]        tot_r, tot_nxt;
  logic [12:0]        big_r, big_nxt;
  logic [9:0]         cnt_r, cnt_nxt;
  logic               ov_r, ov_nxt;

  logic               we;
  logic [PTR_W-1:0]   waddr;
  ent_t               wdata, rd;
  logic [OFF_W-1:0]   s_off, n_off, ns_off, m_off, sz_up;
  logic [OFF_W-1:0]   merged, f_off;

  ffpa_ram #(.WIDTH(ENT_W), .DEPTH(NGRAN)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ptr_nxt), .rdata(rd)
  );

  assign s_off  = OFF_W'({ptr_r, GRAN_LG'(0)});
  assign n_off  = s_off + OFF_W'(HEADER_BYTES) + OFF_W'(rd.bytes);
  assign ns_off = s_off + OFF_W'(HEADER_BYTES) + rsize_r;
  assign merged = OFF_W'(cur_b_r) + OFF_W'(rd.bytes) + OFF_W'(HEADER_BYTES);
  assign m_off  = OFF_W'({cur_g_r, GRAN_LG'(0)}) + OFF_W'(HEADER_BYTES) + merged;
  assign sz_up  = (OFF_W'(in_req_size) + OFF_W'(GRANULE_BYTES - 1))
                  & ~OFF_W'(GRANULE_BYTES - 1);
  assign f_off  = OFF_W'(in_req_addr) - OFF_W'(HEADER_BYTES);

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    ptr_nxt    = ptr_r;
    rsize_nxt  = rsize_r;
    status_nxt = status_r;
    daddr_nxt  = daddr_r;
    cur_g_nxt  = cur_g_r;
    cur_fr_nxt = cur_fr_r;
    cur_b_nxt  = cur_b_r;
    dirty_nxt  = dirty_r;
    tot_nxt    = tot_r;
    big_nxt    = big_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = 1'b0;
    we         = 1'b0;
    waddr      = ptr_r;
    wdata      = '0;
    case (state_r)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_r[PTR_W-1:0];
        if (clr_r == '0) begin
          wdata = '{st: 1'b1, fr: 1'b1, bytes: BYTES_W'(POOL_BYTES - HEADER_BYTES)};
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (PTR_W+1)'(NGRAN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          status_nxt = ST_OK;
          daddr_nxt  = '0;
          rsize_nxt  = sz_up;
          case (in_req_type)
            REQ_ALLOC: begin
              if (in_req_size == '0) begin
                status_nxt = ST_ZERO;
                state_nxt  = S_ST_INIT;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_A_WALK;
              end
            end
            REQ_FREE: begin
              if (in_req_addr < 13'(HEADER_BYTES) || f_off >= OFF_W'(POOL_BYTES)
                  || f_off[GRAN_LG-1:0] != '0) begin
                status_nxt = ST_BAD_ADDR;
                state_nxt  = S_ST_INIT;
              end else begin
                ptr_nxt   = f_off[PTR_W+GRAN_LG-1:GRAN_LG];
                state_nxt = S_F_CHK;
              end
            end
            default: state_nxt = S_ST_INIT;
          endcase
        end
      end
      S_A_WALK: begin
        if (rd.fr && OFF_W'(rd.bytes) >= rsize_r) begin
          daddr_nxt = 12'(s_off + OFF_W'(HEADER_BYTES));
          we        = 1'b1;
          if (OFF_W'(rd.bytes) > rsize_r + OFF_W'(HEADER_BYTES + GRANULE_BYTES)) begin
            // split: write the remainder now, the granted block next cycle
            waddr     = ns_off[PTR_W+GRAN_LG-1:GRAN_LG];
            wdata     = '{st: 1'b1, fr: 1'b1,
                          bytes: BYTES_W'(OFF_W'(rd.bytes) - rsize_r
                                          - OFF_W'(HEADER_BYTES))};
            state_nxt = S_A_W2;
          end else begin
            wdata     = '{st: 1'b1, fr: 1'b0, bytes: rd.bytes};
            state_nxt = S_ST_INIT;
          end
        end else if (n_off >= OFF_W'(POOL_BYTES)) begin
          status_nxt = ST_NO_FIT;
          state_nxt  = S_ST_INIT;
        end else begin
          ptr_nxt = n_off[PTR_W+GRAN_LG-1:GRAN_LG];
        end
      end
      S_A_W2: begin
        we        = 1'b1;
        wdata     = '{st: 1'b1, fr: 1'b0, bytes: BYTES_W'(rsize_r)};
        state_nxt = S_ST_INIT;
      end
      S_F_CHK: begin
        if (!rd.st) begin
          status_nxt = ST_BAD_ADDR;
          state_nxt  = S_ST_INIT;
        end else begin
          we        = 1'b1;
          wdata     = '{st: 1'b1, fr: 1'b1, bytes: rd.bytes};
          state_nxt = S_M_INIT;
        end
      end
      S_M_INIT: begin
        ptr_nxt   = '0;
        dirty_nxt = 1'b0;
        state_nxt = S_M_CUR;
      end
      S_M_CUR, S_M_NXT: begin
        if (state_r == S_M_NXT && cur_fr_r && rd.fr) begin
          // absorb the next block and drop its entry
          we        = 1'b1;
          wdata     = '0;
          cur_b_nxt = BYTES_W'(merged);
          dirty_nxt = 1'b1;
          if (m_off >= OFF_W'(POOL_BYTES)) begin
            state_nxt = S_M_FLUSH;
          end else begin
            ptr_nxt = m_off[PTR_W+GRAN_LG-1:GRAN_LG];
          end
        end else begin
          if (dirty_r) begin
            we    = 1'b1;
            waddr = cur_g_r;
            wdata = '{st: 1'b1, fr: 1'b1, bytes: cur_b_r};
          end
          cur_g_nxt  = ptr_r;
          cur_fr_nxt = rd.fr;
          cur_b_nxt  = rd.bytes;
          dirty_nxt  = 1'b0;
          if (n_off >= OFF_W'(POOL_BYTES)) begin
            state_nxt = S_ST_INIT;
          end else begin
            ptr_nxt   = n_off[PTR_W+GRAN_LG-1:GRAN_LG];
            state_nxt = S_M_NXT;
          end
        end
      end
      S_M_FLUSH: begin
        we        = 1'b1;
        waddr     = cur_g_r;
        wdata     = '{st: 1'b1, fr: 1'b1, bytes: cur_b_r};
        dirty_nxt = 1'b0;
        state_nxt = S_ST_INIT;
      end
      S_ST_INIT: begin
        ptr_nxt   = '0;
        tot_nxt   = '0;
        big_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_ST_WALK;
      end
      S_ST_WALK: begin
        if (rd.fr) begin
          tot_nxt = tot_r + 13'(rd.bytes);
          cnt_nxt = cnt_r + 1'b1;
          if (13'(rd.bytes) > big_r) begin
            big_nxt = 13'(rd.bytes);
          end
        end
        if (n_off >= OFF_W'(POOL_BYTES)) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = n_off[PTR_W+GRAN_LG-1:GRAN_LG];
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ptr_r   <= '0;
      dirty_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ptr_r   <= ptr_nxt;
      dirty_r <= dirty_nxt;
      ov_r    <= ov_nxt;
    end
    rsize_r  <= rsize_nxt;
    status_r <= status_nxt;
    daddr_r  <= daddr_nxt;
    cur_g_r  <= cur_g_nxt;
    cur_fr_r <= cur_fr_nxt;
    cur_b_r  <= cur_b_nxt;
    tot_r    <= tot_nxt;
    big_r    <= big_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_status       = status_r;
  assign out_data_addr    = daddr_r;
  assign out_total_free   = tot_r;
  assign out_largest_free = big_r;
  assign out_free_count   = cnt_r;

`ifndef NO_ASSERTIONS
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("transfer did not start work");
  a_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_largest_free <= out_total_free) else $error("largest above total");
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data_addr == '0)
    else $error("address on failed request");
`endif
endmodule

// File: verif/first_fit_pool_allocator_test.sv
// Self-checking testbench for the first-fit pool allocator.
`timescale 1ns / 1ps

module first_fit_pool_allocator_test;
  import ffpa_pkg::*;

  typedef struct {
    status_t     status;
    logic [11:0] data_addr;
    logic [12:0] total_free;
    logic [12:0] largest_free;
    logic [9:0]  free_count;
  } alloc_result_t;

  // Block-list mirror: predicts each allocator response.
  class pool_scoreboard;
    bit          blk_start[NGRAN];
    bit          blk_free[NGRAN];
    int unsigned blk_bytes[NGRAN];
    alloc_result_t pending[$];
    int mismatches;
    int checked;

    function void clear_pool();
      for (int i = 0; i < NGRAN; i++) begin
        blk_start[i] = 0;
        blk_free[i] = 0;
        blk_bytes[i] = 0;
      end
      blk_start[0] = 1;
      blk_free[0] = 1;
      blk_bytes[0] = POOL_BYTES - HEADER_BYTES;
    endfunction

    function int unsigned after(int unsigned s);
      return s + HEADER_BYTES + blk_bytes[s / GRANULE_BYTES];
    endfunction

    function void coalesce();
      int unsigned s, n, g, ng, guard;
      s = 0;
      guard = 0;
      while (s < POOL_BYTES && guard <= NGRAN) begin
        g = s / GRANULE_BYTES;
        n = after(s);
        guard++;
        if (n >= POOL_BYTES) break;
        ng = n / GRANULE_BYTES;
        if (blk_free[g] && blk_free[ng]) begin
          blk_bytes[g] += blk_bytes[ng] + HEADER_BYTES;
          blk_start[ng] = 0;
          blk_free[ng] = 0;
          blk_bytes[ng] = 0;
        end else begin
          s = n;
        end
      end
    endfunction

    function status_t grant(int unsigned size, output int unsigned addr);
      int unsigned s, g, ns, ng, guard;
      s = 0;
      guard = 0;
      addr = 0;
      if (size == 0) return ST_ZERO;
      size = ((size + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
      while (s < POOL_BYTES && guard <= NGRAN) begin
        g = s / GRANULE_BYTES;
        guard++;
        if (blk_free[g] && blk_bytes[g] >= size) begin
          if (blk_bytes[g] > size + HEADER_BYTES + GRANULE_BYTES) begin
            ns = s + HEADER_BYTES + size;
            ng = ns / GRANULE_BYTES;
            if (ng < NGRAN) begin
              blk_start[ng] = 1;
              blk_free[ng] = 1;
              blk_bytes[ng] = blk_bytes[g] - size - HEADER_BYTES;
              blk_bytes[g] = size;
            end
          end
          blk_free[g] = 0;
          addr = s + HEADER_BYTES;
          return ST_OK;
        end
        s = after(s);
      end
      return ST_NO_FIT;
    endfunction

    function status_t release_block(int unsigned addr);
      int unsigned s;
      if (addr < HEADER_BYTES) return ST_BAD_ADDR;
      s = addr - HEADER_BYTES;
      if (s >= POOL_BYTES || (s % GRANULE_BYTES) != 0) return ST_BAD_ADDR;
      if (!blk_start[s / GRANULE_BYTES]) return ST_BAD_ADDR;
      blk_free[s / GRANULE_BYTES] = 1;
      coalesce();
      return ST_OK;
    endfunction

    function void note_request(req_t kind, int unsigned size, int unsigned addr);
      alloc_result_t r;
      int unsigned s, g, guard, granted, total, largest, count;
      granted = 0;
      r.status = ST_OK;
      if (kind == REQ_ALLOC) r.status = grant(size, granted);
      else if (kind == REQ_FREE) r.status = release_block(addr);
      total = 0;
      largest = 0;
      count = 0;
      s = 0;
      guard = 0;
      while (s < POOL_BYTES && guard <= NGRAN) begin
        g = s / GRANULE_BYTES;
        guard++;
        if (blk_free[g]) begin
          total += blk_bytes[g];
          count++;
          if (blk_bytes[g] > largest) largest = blk_bytes[g];
        end
        s = after(s);
      end
      r.data_addr = granted[11:0];
      r.total_free = total[12:0];
      r.largest_free = largest[12:0];
      r.free_count = count[9:0];
      pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d", got.status);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.status != exp.status || got.data_addr != exp.data_addr ||
          got.total_free != exp.total_free || got.largest_free != exp.largest_free ||
          got.free_count != exp.free_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch exp st=%0d a=%0d tf=%0d lf=%0d fc=%0d",
                 exp.status, exp.data_addr, exp.total_free, exp.largest_free,
                 exp.free_count);
          $display(" got st=%0d a=%0d tf=%0d lf=%0d fc=%0d",
                   got.status, got.data_addr, got.total_free,
                   got.largest_free, got.free_count);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [12:0] in_req_size;
  logic [12:0] in_req_addr;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [11:0] out_data_addr;
  logic [12:0] out_total_free;
  logic [12:0] out_largest_free;
  logic [9:0]  out_free_count;

  first_fit_pool_allocator DUT (.*);

  pool_scoreboard board;
  int unsigned live_addrs[$];
  int idle_pct;
  int cycles;
  int sent;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Bound: worst-case item time plus idling, for ~530 items.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t got;
    if (rst_n && out_valid) begin
      got.status = status_t'(out_status);
      got.data_addr = out_data_addr;
      got.total_free = out_total_free;
      got.largest_free = out_largest_free;
      got.free_count = out_free_count;
      board.check_result(got);
    end
  end

  // Start stays high after a transfer until the next idle gap or the end of
  // the run; busy holds off a second transfer meanwhile.
  task automatic send_request(req_t kind, int unsigned size, int unsigned addr);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= kind;
    in_req_size <= size[12:0];
    in_req_addr <= addr[12:0];
    do @(posedge clk); while (busy);
    // transfer taken at this edge
    board.note_request(kind, size, addr);
    sent++;
  endtask

  // Track granted offsets so that most frees hit real block starts.
  task automatic alloc_tracked(int unsigned size);
    send_request(REQ_ALLOC, size, $urandom_range(8191));
    if (board.pending[$].status == ST_OK)
      live_addrs.push_back(board.pending[$].data_addr);
  endtask

  task automatic free_tracked();
    int idx;
    idx = $urandom_range(live_addrs.size() - 1);
    send_request(REQ_FREE, $urandom_range(8191), live_addrs[idx]);
    live_addrs.delete(idx);
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(9) == 0) alloc_tracked($urandom_range(8191));
      else alloc_tracked($urandom_range(1, 300));
    end else if (pick < 80 && live_addrs.size() > 0) begin
      free_tracked();
    end else if (pick < 90) begin
      send_request(REQ_FREE, $urandom_range(8191), $urandom_range(8191));
    end else begin
      send_request(req_t'($urandom_range(2, 3)), $urandom_range(8191),
                   $urandom_range(8191));
    end
  endtask

  initial begin
    board = new();
    board.clear_pool();
    rst_n = 0;
    start = 0;
    in_req_type = REQ_QUERY;
    in_req_size = '0;
    in_req_addr = '0;
    idle_pct = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each request kind and each error path.
    send_request(REQ_QUERY, 0, 0);
    send_request(REQ_SPARE, 8191, 8191);
    send_request(REQ_ALLOC, 0, 0);
    send_request(REQ_ALLOC, 8191, 0);
    send_request(REQ_ALLOC, 4081, 0);
    send_request(REQ_FREE, 0, 0);
    send_request(REQ_FREE, 0, 15);
    send_request(REQ_FREE, 0, 8191);
    send_request(REQ_FREE, 0, 4112);
    send_request(REQ_FREE, 0, 17);
    send_request(REQ_FREE, 0, 16);
    alloc_tracked(1);
    alloc_tracked(8);
    alloc_tracked(9);
    send_request(REQ_FREE, 0, 24);
    send_request(REQ_FREE, 0, 64);
    send_request(REQ_FREE, 0, 16);
    alloc_tracked(4080);
    send_request(REQ_QUERY, 0, 0);
    while (live_addrs.size() > 0) free_tracked();
    alloc_tracked(4048);
    alloc_tracked(4055);
    free_tracked();

    // Random phases with changing idle pressure.
    idle_pct = 18;
    repeat (170) random_item();
    idle_pct = 50;
    repeat (165) random_item();
    idle_pct = 0;
    repeat (165) random_item();
    start <= 1'b0;

    while (board.pending.size() > 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    $display("sent %0d requests, checked %0d responses, %0d mismatches",
             sent, board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// File: sim.f
rtl/ffpa_pkg.sv
rtl/ffpa_ram.sv
rtl/first_fit_pool_allocator.sv
verif/first_fit_pool_allocator_test.sv
